### hdl/jms_pkg.sv
// ----------------------------------------------------------------------------
// jms_pkg: shared types and constants of the JSON member scanner
// Byte classes passed from the front to the back, value kinds, and the
// request layouts that travel through the two queues.
// ----------------------------------------------------------------------------
package jms_pkg;

  localparam int unsigned PosW       = 16;   // offsets wrap modulo 2^16
  localparam int unsigned DepthW     = 8;
  localparam int unsigned MaxNesting = 255;
  localparam int unsigned NumW       = 64;
  localparam int unsigned TokDepth   = 4;
  localparam int unsigned TokPtrW    = 2;
  localparam int unsigned ResDepth   = 2;
  localparam int unsigned ResPtrW    = 1;

  // Byte classes; every byte falls in exactly one.
  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_COMMA,
    CLS_NULL,
    CLS_TRUE,
    CLS_FALSE,
    CLS_MINUS,
    CLS_DIGIT
  } byte_cls_e;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_NULL    = 3'd1,
    KIND_BOOLEAN = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_OBJECT  = 3'd5
  } kind_e;

  // Classified byte request, front to back.
  typedef struct packed {
    byte_cls_e        cls;
    logic [3:0]       digit;
    logic             start;
    logic [PosW-1:0]  pos;
  } tok_t;

  // One member result, back to the result ports.
  typedef struct packed {
    logic [PosW-1:0]        key_offset;
    logic [PosW-1:0]        key_length;
    kind_e                  value_kind;
    logic [PosW-1:0]        value_offset;
    logic [PosW-1:0]        value_length;
    logic signed [NumW-1:0] number_value;
    logic                   truth_value;
    logic                   last_member;
  } res_t;

endpackage

### hdl/jms_front.sv
// ----------------------------------------------------------------------------
// jms_front: byte intake and classification
// Tracks the byte offset within the document and tags each byte with its
// class, digit value and offset before it enters the token queue.
// ----------------------------------------------------------------------------
module jms_front import jms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] text_byte_i,
  input  logic       starts_document_i,
  output logic       tok_wr_o,
  output tok_t       tok_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos;
  byte_cls_e       cls;

  always_comb begin
    unique case (text_byte_i)
      8'h7B:               cls = CLS_LBRACE;  // '{'
      8'h7D:               cls = CLS_RBRACE;  // '}'
      8'h22:               cls = CLS_QUOTE;
      8'h5C:               cls = CLS_BSLASH;
      8'h2C:               cls = CLS_COMMA;
      8'h6E, 8'h4E:        cls = CLS_NULL;    // 'n' 'N'
      8'h74, 8'h54:        cls = CLS_TRUE;    // 't' 'T'
      8'h66, 8'h46:        cls = CLS_FALSE;   // 'f' 'F'
      8'h2D:               cls = CLS_MINUS;
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39:
                           cls = CLS_DIGIT;
      default:             cls = CLS_OTHER;
    endcase
  end

  // A start byte is offset zero whatever came before.
  assign pos      = starts_document_i ? '0 : pos_q;
  assign tok_wr_o = push_i && !full_i;
  assign pos_d    = tok_wr_o ? pos + 1'b1 : pos_q;

  assign tok_o.cls   = cls;
  assign tok_o.digit = text_byte_i[3:0];
  assign tok_o.start = starts_document_i;
  assign tok_o.pos   = pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

### hdl/jms_tok_queue.sv
// ----------------------------------------------------------------------------
// jms_tok_queue: queue of classified bytes
// Decouples byte intake from the scan engine so each side stalls alone.
// ----------------------------------------------------------------------------
module jms_tok_queue import jms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  tok_t tok_i,
  output logic full_o,
  input  logic rd_i,
  output tok_t tok_o,
  output logic empty_o
);

  tok_t                mem_q [TokDepth];
  logic [TokPtrW-1:0]  wptr_q, rptr_q;
  logic [TokPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (TokPtrW+1)'(TokDepth));
  assign empty_o = (cnt_q == '0);
  assign tok_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (TokPtrW+1)'(TokDepth))
    else $error("token queue count above depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("token queue read while empty");

endmodule

### hdl/jms_back.sv
// ----------------------------------------------------------------------------
// jms_back: member scan engine
// Walks the classified bytes of one document, tracks key and value extents,
// decodes numbers and issues one result request per top-level member.
// ----------------------------------------------------------------------------
module jms_back import jms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  input  logic tok_empty_i,
  output logic tok_rd_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_KEY_QUOTE,
    PH_KEY,
    PH_COLON,
    PH_VALUE_START,
    PH_OBJECT,
    PH_STRING,
    PH_TAIL
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              bslash_q, bslash_d;
  logic [PosW-1:0]   key_start_q, key_start_d;
  logic [PosW-1:0]   key_count_q, key_count_d;
  logic [PosW-1:0]   val_start_q, val_start_d;
  logic [PosW-1:0]   val_count_q, val_count_d;
  kind_e             kind_q, kind_d;
  logic [NumW-1:0]   acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              dend_q, dend_d;

  logic              fire;
  logic              emit;
  logic              emit_last;
  logic [NumW-1:0]   acc_x10;
  logic [NumW-1:0]   num_signed;

  // Advance only when a byte waits and the result queue has room.
  assign fire     = !tok_empty_i && !res_full_i;
  assign tok_rd_o = fire;

  assign acc_x10 = {acc_q[NumW-4:0], 3'b000} + {acc_q[NumW-2:0], 1'b0}
                 + {{(NumW-4){1'b0}}, tok_i.digit};

  always_comb begin
    phase_d     = phase_q;
    depth_d     = depth_q;
    bslash_d    = bslash_q;
    key_start_d = key_start_q;
    key_count_d = key_count_q;
    val_start_d = val_start_q;
    val_count_d = val_count_q;
    kind_d      = kind_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    dend_d      = dend_q;
    emit        = 1'b0;
    emit_last   = 1'b0;

    if (fire) begin
      if (tok_i.start) begin
        phase_d = (tok_i.cls == CLS_LBRACE) ? PH_KEY_QUOTE : PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_KEY_QUOTE: begin
            key_start_d = tok_i.pos + 1'b1;
            key_count_d = '0;
            bslash_d    = 1'b0;
            phase_d     = PH_KEY;
          end
          PH_KEY: begin
            if (tok_i.cls == CLS_QUOTE && !bslash_q) begin
              phase_d = PH_COLON;
            end else begin
              key_count_d = key_count_q + 1'b1;
              bslash_d    = (tok_i.cls == CLS_BSLASH);
            end
          end
          PH_COLON: begin
            phase_d = PH_VALUE_START;
          end
          PH_VALUE_START: begin
            val_start_d = tok_i.pos;
            val_count_d = '0;
            acc_d       = '0;
            neg_d       = 1'b0;
            dend_d      = 1'b0;
            phase_d     = PH_TAIL;
            kind_d      = KIND_UNKNOWN;
            case (tok_i.cls)
              CLS_LBRACE: begin
                kind_d      = KIND_OBJECT;
                depth_d     = DepthW'(1);
                val_count_d = PosW'(1);
                phase_d     = PH_OBJECT;
              end
              CLS_QUOTE: begin
                kind_d      = KIND_STRING;
                val_start_d = tok_i.pos + 1'b1;
                bslash_d    = 1'b0;
                phase_d     = PH_STRING;
              end
              CLS_NULL: kind_d = KIND_NULL;
              CLS_TRUE, CLS_FALSE: begin
                kind_d = KIND_BOOLEAN;
                neg_d  = (tok_i.cls == CLS_TRUE);
              end
              CLS_MINUS: begin
                kind_d = KIND_NUMBER;
                neg_d  = 1'b1;
              end
              CLS_DIGIT: begin
                kind_d = KIND_NUMBER;
                acc_d  = {{(NumW-4){1'b0}}, tok_i.digit};
              end
              CLS_COMMA: begin
                emit    = 1'b1;
                phase_d = PH_KEY_QUOTE;
              end
              CLS_RBRACE: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                phase_d   = PH_IDLE;
              end
              default: begin
              end
            endcase
          end
          PH_OBJECT: begin
            val_count_d = val_count_q + 1'b1;
            if (tok_i.cls == CLS_LBRACE) begin
              if (depth_q < DepthW'(MaxNesting)) depth_d = depth_q + 1'b1;
            end else if (tok_i.cls == CLS_RBRACE) begin
              if (depth_q != '0) depth_d = depth_q - 1'b1;
              if (depth_d == '0) phase_d = PH_TAIL;
            end
          end
          PH_STRING: begin
            if (tok_i.cls == CLS_QUOTE && !bslash_q) begin
              phase_d = PH_TAIL;
            end else begin
              val_count_d = val_count_q + 1'b1;
              bslash_d    = (tok_i.cls == CLS_BSLASH);
            end
          end
          PH_TAIL: begin
            if (kind_q == KIND_STRING || kind_q == KIND_OBJECT) begin
              // Any byte other than a closing brace is the separator.
              emit      = 1'b1;
              emit_last = (tok_i.cls == CLS_RBRACE);
              phase_d   = emit_last ? PH_IDLE : PH_KEY_QUOTE;
            end else begin
              if (kind_q == KIND_NUMBER && !dend_q) begin
                if (tok_i.cls == CLS_DIGIT) begin
                  acc_d = acc_x10;
                end else begin
                  dend_d = 1'b1;
                end
              end
              if (tok_i.cls == CLS_COMMA) begin
                emit    = 1'b1;
                phase_d = PH_KEY_QUOTE;
              end else if (tok_i.cls == CLS_RBRACE) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                phase_d   = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // On an emitting byte of a number the accumulator never changes, so take it as held.
  assign num_signed = neg_q ? ('0 - acc_q) : acc_q;

  assign res_push_o            = emit;
  assign res_o.key_offset      = key_start_d;
  assign res_o.key_length      = key_count_d;
  assign res_o.value_kind      = kind_d;
  assign res_o.value_offset    = val_start_d;
  assign res_o.value_length    = (kind_d == KIND_STRING || kind_d == KIND_OBJECT)
                                 ? val_count_d : '0;
  assign res_o.number_value    = (kind_d == KIND_NUMBER) ? num_signed : '0;
  assign res_o.truth_value     = (kind_d == KIND_BOOLEAN) && neg_d;
  assign res_o.last_member     = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      depth_q     <= '0;
      bslash_q    <= 1'b0;
      key_start_q <= '0;
      key_count_q <= '0;
      val_start_q <= '0;
      val_count_q <= '0;
      kind_q      <= KIND_UNKNOWN;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      dend_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      depth_q     <= depth_d;
      bslash_q    <= bslash_d;
      key_start_q <= key_start_d;
      key_count_q <= key_count_d;
      val_start_q <= val_start_d;
      val_count_q <= val_count_d;
      kind_q      <= kind_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      dend_q      <= dend_d;
    end
  end

  a_obj_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OBJECT) |-> (depth_q != '0))
    else $error("object phase with zero nesting depth");

  a_push_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (fire && !tok_i.start))
    else $error("result request without a consumed byte");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && tok_i.start && tok_i.cls != CLS_LBRACE) |=> (phase_q == PH_IDLE))
    else $error("restart without opening brace did not go idle");

endmodule

### hdl/jms_res_queue.sv
// ----------------------------------------------------------------------------
// jms_res_queue: result queue
// Holds finished member results until the consumer pops them.
// ----------------------------------------------------------------------------
module jms_res_queue import jms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  res_t res_i,
  output logic full_o,
  input  logic rd_i,
  output res_t res_o,
  output logic empty_o
);

  res_t                mem_q [ResDepth];
  logic [ResPtrW-1:0]  wptr_q, rptr_q;
  logic [ResPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (ResPtrW+1)'(ResDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/json_member_scanner.sv
// ----------------------------------------------------------------------------
// json_member_scanner: top-level member scanner for whitespace-free JSON
// Feed one document byte per push, with starts_document_i high on the first
// byte of each document. For every member of the outer object one result
// comes out: key offset and length, value kind, value offset and length,
// the decoded decimal number (wrapping modulo 2^64), a truth flag and a mark
// for the member closed by the final '}'. Documents that do not open with
// '{' give nothing. The block sustains one byte per clock cycle while the
// result queue has room. An accepted byte is written into the byte queue and
// scanned from its head; the result it completes is written into the result
// queue and driven onto the result ports from there. The scan engine's single
// pass over a byte's state update (a shift-and-add times ten on the 64-bit
// accumulator) keeps it at one byte per cycle. A result waits in a two-entry
// queue while new bytes keep flowing; when that queue fills the engine holds
// and the four-entry byte queue absorbs the stall before full rises.
// ----------------------------------------------------------------------------
module json_member_scanner import jms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte requests
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             text_byte_i,
  input  logic                   starts_document_i,
  // result requests
  output logic                   empty,
  input  logic                   pop,
  output logic [15:0]            key_offset_o,
  output logic [15:0]            key_length_o,
  output logic [2:0]             value_kind_o,
  output logic [15:0]            value_offset_o,
  output logic [15:0]            value_length_o,
  output logic signed [63:0]     number_value_o,
  output logic                   truth_value_o,
  output logic                   last_member_o
);

  tok_t tok_wr_data, tok_rd_data;
  logic tok_wr, tok_rd, tok_empty;
  logic res_push, res_full;
  res_t res_wr_data, res_rd_data;

  // Classify and stamp each byte with its offset.
  jms_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .text_byte_i       (text_byte_i),
    .starts_document_i (starts_document_i),
    .tok_wr_o          (tok_wr),
    .tok_o             (tok_wr_data)
  );

  // Buffer classified bytes so intake never waits on a result stall directly.
  jms_tok_queue u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tok_wr),
    .tok_i   (tok_wr_data),
    .full_o  (full),
    .rd_i    (tok_rd),
    .tok_o   (tok_rd_data),
    .empty_o (tok_empty)
  );

  // Scan one byte per cycle while a byte waits and the result queue has room, and issue member results.
  jms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_rd_data),
    .tok_empty_i (tok_empty),
    .tok_rd_o    (tok_rd),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wr_data)
  );

  // Hold finished results until popped.
  jms_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .res_i   (res_wr_data),
    .full_o  (res_full),
    .rd_i    (pop && !empty),
    .res_o   (res_rd_data),
    .empty_o (empty)
  );

  // Drive the oldest waiting result onto the ports.
  assign key_offset_o   = res_rd_data.key_offset;
  assign key_length_o   = res_rd_data.key_length;
  assign value_kind_o   = res_rd_data.value_kind;
  assign value_offset_o = res_rd_data.value_offset;
  assign value_length_o = res_rd_data.value_length;
  assign number_value_o = res_rd_data.number_value;
  assign truth_value_o  = res_rd_data.truth_value;
  assign last_member_o  = res_rd_data.last_member;

endmodule

### bench/json_member_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_member_scanner_tb: self-checking bench for the JSON member scanner
// Streams whitespace-free JSON documents into the block one byte request at a
// time, tracks the scan in a model of its own to predict every member, and
// compares each popped result request field by field against the oldest
// prediction. Sender and receiver idle at random, and one long receiver hold
// fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module json_member_scanner_tb import jms_pkg::*;;

  localparam int unsigned RandomBytes = 140;     // per random phase
  localparam int unsigned HoldCycles  = 300;     // receiver hold-off
  localparam int unsigned DeepBraces  = 260;     // past the depth counter
  localparam int unsigned StallLimit  = 5000;    // cycles with no request moved
  localparam int unsigned DrainCycles = 16;

  // Bytes that steer the scan.
  localparam logic [7:0] CH_LBRACE  = "{";
  localparam logic [7:0] CH_RBRACE  = "}";
  localparam logic [7:0] CH_QUOTE   = "\"";
  localparam logic [7:0] CH_BSLASH  = "\\";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_COLON   = ":";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_NULL_L  = "n";
  localparam logic [7:0] CH_NULL_U  = "N";
  localparam logic [7:0] CH_TRUE_L  = "t";
  localparam logic [7:0] CH_TRUE_U  = "T";
  localparam logic [7:0] CH_FALSE_L = "f";
  localparam logic [7:0] CH_FALSE_U = "F";

  // Where the scan stands between bytes.
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_KEY_OPEN,
    SC_KEY,
    SC_COLON,
    SC_VALUE,
    SC_OBJECT,
    SC_STRING,
    SC_TAIL
  } scan_state_e;

  logic                clk;
  logic                rst_ni            = 1'b0;
  logic                push              = 1'b0;
  logic                full;
  logic [7:0]          text_byte_i       = 8'h00;
  logic                starts_document_i = 1'b0;
  logic                empty;
  logic                pop               = 1'b0;
  logic [15:0]         key_offset_o;
  logic [15:0]         key_length_o;
  logic [2:0]          value_kind_o;
  logic [15:0]         value_offset_o;
  logic [15:0]         value_length_o;
  logic signed [63:0]  number_value_o;
  logic                truth_value_o;
  logic                last_member_o;

  json_member_scanner dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .text_byte_i       (text_byte_i),
    .starts_document_i (starts_document_i),
    .empty             (empty),
    .pop               (pop),
    .key_offset_o      (key_offset_o),
    .key_length_o      (key_length_o),
    .value_kind_o      (value_kind_o),
    .value_offset_o    (value_offset_o),
    .value_length_o    (value_length_o),
    .number_value_o    (number_value_o),
    .truth_value_o     (truth_value_o),
    .last_member_o     (last_member_o)
  );

  // Scan model state; reset values match the block after reset.
  scan_state_e  sc_state       = SC_IDLE;
  logic [15:0]  sc_pos         = '0;
  logic [7:0]   sc_depth       = '0;
  logic         sc_esc         = 1'b0;
  logic [15:0]  sc_key_off     = '0;
  logic [15:0]  sc_key_len     = '0;
  logic [15:0]  sc_val_off     = '0;
  logic [15:0]  sc_val_len     = '0;
  kind_e        sc_kind        = KIND_UNKNOWN;
  logic [63:0]  sc_num         = '0;
  logic         sc_neg         = 1'b0;   // doubles as the truth flag for booleans
  logic         sc_digits_done = 1'b0;

  res_t         member_q[$];             // predicted members, oldest first
  int unsigned  errors         = 0;
  int unsigned  tx_idle_pct    = 0;
  int unsigned  rx_idle_pct    = 0;
  logic         rx_hold        = 1'b0;
  event         hold_rx_ev;

  // Output state sampled at the falling edge, used at the next rising edge.
  logic         full_s         = 1'b1;
  logic         empty_s        = 1'b1;
  res_t         seen;

  int unsigned  quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    full_s             = full;
    empty_s            = empty;
    seen.key_offset    = key_offset_o;
    seen.key_length    = key_length_o;
    seen.value_kind    = kind_e'(value_kind_o);
    seen.value_offset  = value_offset_o;
    seen.value_length  = value_length_o;
    seen.number_value  = number_value_o;
    seen.truth_value   = truth_value_o;
    seen.last_member   = last_member_o;
  end

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------
  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Queue the member in progress and move on to the next key or to idle.
  function automatic void close_member(input logic last);
    res_t m;
    m.key_offset   = sc_key_off;
    m.key_length   = sc_key_len;
    m.value_kind   = sc_kind;
    m.value_offset = sc_val_off;
    m.value_length = (sc_kind == KIND_STRING || sc_kind == KIND_OBJECT) ? sc_val_len : '0;
    m.number_value = (sc_kind == KIND_NUMBER) ? (sc_neg ? -sc_num : sc_num) : '0;
    m.truth_value  = (sc_kind == KIND_BOOLEAN) && sc_neg;
    m.last_member  = last;
    member_q.push_back(m);
    sc_state = last ? SC_IDLE : SC_KEY_OPEN;
  endfunction

  // Advance the scan by one accepted byte.
  task automatic scan_byte(input logic [7:0] c, input logic first);
    logic [15:0] pos;
    pos    = first ? 16'd0 : sc_pos;
    sc_pos = pos + 16'd1;
    if (first) begin
      sc_state = (c == CH_LBRACE) ? SC_KEY_OPEN : SC_IDLE;
      return;
    end
    case (sc_state)
      SC_KEY_OPEN: begin
        // The byte before the key text is skipped unchecked.
        sc_key_off = pos + 16'd1;
        sc_key_len = '0;
        sc_esc     = 1'b0;
        sc_state   = SC_KEY;
      end
      SC_KEY: begin
        if (c == CH_QUOTE && !sc_esc) begin
          sc_state = SC_COLON;
        end else begin
          sc_key_len = sc_key_len + 16'd1;
          sc_esc     = (c == CH_BSLASH);
        end
      end
      SC_COLON: sc_state = SC_VALUE;
      SC_VALUE: begin
        sc_val_off     = pos;
        sc_val_len     = '0;
        sc_num         = '0;
        sc_neg         = 1'b0;
        sc_digits_done = 1'b0;
        if (c == CH_LBRACE) begin
          sc_kind    = KIND_OBJECT;
          sc_depth   = 8'd1;
          sc_val_len = 16'd1;
          sc_state   = SC_OBJECT;
        end else if (c == CH_QUOTE) begin
          sc_kind    = KIND_STRING;
          sc_val_off = pos + 16'd1;
          sc_esc     = 1'b0;
          sc_state   = SC_STRING;
        end else begin
          // The first byte decides a literal's kind; it may also end the member.
          if (c == CH_NULL_L || c == CH_NULL_U) begin
            sc_kind = KIND_NULL;
          end else if (c == CH_TRUE_L || c == CH_TRUE_U ||
                       c == CH_FALSE_L || c == CH_FALSE_U) begin
            sc_kind = KIND_BOOLEAN;
            sc_neg  = (c == CH_TRUE_L || c == CH_TRUE_U);
          end else if (c == CH_MINUS || is_digit(c)) begin
            sc_kind = KIND_NUMBER;
            if (c == CH_MINUS) sc_neg = 1'b1;
            else sc_num = 64'(c - CH_ZERO);
          end else begin
            sc_kind = KIND_UNKNOWN;
          end
          sc_state = SC_TAIL;
          if (c == CH_COMMA) close_member(1'b0);
          else if (c == CH_RBRACE) close_member(1'b1);
        end
      end
      SC_OBJECT: begin
        sc_val_len = sc_val_len + 16'd1;
        if (c == CH_LBRACE) begin
          if (sc_depth < MaxNesting) sc_depth = sc_depth + 8'd1;
        end else if (c == CH_RBRACE) begin
          if (sc_depth != 0) sc_depth = sc_depth - 8'd1;
          if (sc_depth == 0) sc_state = SC_TAIL;
        end
      end
      SC_STRING: begin
        if (c == CH_QUOTE && !sc_esc) begin
          sc_state = SC_TAIL;
        end else begin
          sc_val_len = sc_val_len + 16'd1;
          sc_esc     = (c == CH_BSLASH);
        end
      end
      SC_TAIL: begin
        if (sc_kind == KIND_STRING || sc_kind == KIND_OBJECT) begin
          // Any byte but a closing brace counts as the separator here.
          close_member(c == CH_RBRACE);
        end else begin
          if (sc_kind == KIND_NUMBER && !sc_digits_done) begin
            if (is_digit(c)) sc_num = sc_num * 64'd10 + 64'(c - CH_ZERO);
            else sc_digits_done = 1'b1;
          end
          if (c == CH_COMMA) close_member(1'b0);
          else if (c == CH_RBRACE) close_member(1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Document builders
  // --------------------------------------------------------------------------
  function automatic void add_str(ref logic [7:0] q[$], input string s);
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Text for keys and strings: mostly letters, with escaped quotes and stray
  // braces now and then.
  function automatic void add_chars(ref logic [7:0] q[$], input int unsigned n);
    string pool;
    int unsigned k;
    pool = "abcxyzQR09:,-";
    for (k = 0; k < n; k++) begin
      case ($urandom_range(15))
        0:       begin q.push_back(CH_BSLASH); q.push_back(CH_QUOTE); end
        1:       q.push_back($urandom_range(1) ? CH_LBRACE : CH_RBRACE);
        default: q.push_back(pool[$urandom_range(pool.len() - 1)]);
      endcase
    end
  endfunction

  function automatic void add_member(ref logic [7:0] q[$], input int unsigned level);
    q.push_back(CH_QUOTE);
    add_chars(q, $urandom_range(0, 5));
    q.push_back(CH_QUOTE);
    q.push_back(CH_COLON);
    add_value(q, level);
  endfunction

  function automatic void add_value(ref logic [7:0] q[$], input int unsigned level);
    string odd;
    int unsigned n, i;
    odd = "[x@?";
    case ($urandom_range(7))
      0: begin
        if ($urandom_range(1)) add_str(q, "null");
        else add_str(q, "Nul");
      end
      1: begin
        if ($urandom_range(1)) add_str(q, "true");
        else add_str(q, "True");
      end
      2: begin
        if ($urandom_range(1)) add_str(q, "false");
        else add_str(q, "F");
      end
      3: begin
        if ($urandom_range(2) == 0) q.push_back(CH_MINUS);
        // Long digit runs can wrap the accumulator.
        n = ($urandom_range(9) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 5);
        repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(5) == 0) add_str(q, ".5e1");
      end
      4: begin
        q.push_back(CH_QUOTE);
        add_chars(q, $urandom_range(0, 8));
        q.push_back(CH_QUOTE);
      end
      5: begin
        q.push_back(CH_LBRACE);
        if (level < 3) begin
          n = $urandom_range(0, 3);
          for (i = 0; i < n; i++) begin
            if (i != 0) q.push_back(CH_COMMA);
            add_member(q, level + 1);
          end
        end
        q.push_back(CH_RBRACE);
      end
      6: q.push_back(odd[$urandom_range(odd.len() - 1)]);
      default: ;   // empty value: the separator follows the colon directly
    endcase
  endfunction

  // Mostly well-formed objects with random members; some raw noise, some
  // truncated (the next start drops them) or with one byte corrupted.
  function automatic void build_document(ref logic [7:0] q[$]);
    int unsigned n, i;
    q.delete();
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 24);
      repeat (n) q.push_back(8'($urandom));
      if ($urandom_range(1)) q[0] = CH_LBRACE;
      return;
    end
    q.push_back(CH_LBRACE);
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      if (i != 0) q.push_back(CH_COMMA);
      add_member(q, 0);
    end
    q.push_back(CH_RBRACE);
    // Bytes after the closing brace are ignored.
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
    case ($urandom_range(19))
      0:       repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
      1:       q[$urandom_range(q.size() - 1)] = 8'($urandom);
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one byte request, hold it until accepted, then track it. Push is
  // left high so a following byte goes out back to back.
  task automatic send_byte(input logic [7:0] b, input logic first);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    push              <= 1'b1;
    text_byte_i       <= b;
    starts_document_i <= first;
    do @(posedge clk); while (full_s);
    scan_byte(b, first);
  endtask

  task automatic send_doc(input logic [7:0] q[$]);
    int i;
    for (i = 0; i < q.size(); i++) send_byte(q[i], i == 0);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    add_str(q, s);
    send_doc(q);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_member();
    res_t want;
    if (member_q.size() == 0) begin
      $display("%0t: unexpected member: expected none, actual key_offset %0h kind %0h",
               $time, seen.key_offset, seen.value_kind);
      errors++;
    end else begin
      want = member_q.pop_front();
      check_field("key_offset",   want.key_offset,   seen.key_offset);
      check_field("key_length",   want.key_length,   seen.key_length);
      check_field("value_kind",   want.value_kind,   seen.value_kind);
      check_field("value_offset", want.value_offset, seen.value_offset);
      check_field("value_length", want.value_length, seen.value_length);
      check_field("number_value", want.number_value, seen.number_value);
      check_field("truth_value",  want.truth_value,  seen.truth_value);
      check_field("last_member",  want.last_member,  seen.last_member);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni) begin
      if (pop && !empty_s) check_member();
      pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hold the receiver off for a fixed stretch whenever asked.
  always begin
    @(hold_rx_ev);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Drop out if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((push && !full_s) || (pop && !empty_s)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked documents: each value kind, byte extremes, escapes, restarts.
  task automatic test_directed();
    // Bytes before any document start are ignored.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
    // A document that does not open with a brace gives nothing.
    send_text("x{\"a\":1}");
    // Literals, then bytes after the closing brace.
    send_text("{\"n\":null,\"t\":True,\"f\":false}zz");
    // Negative number, one past 2^64, digits stopping at a dot.
    send_text("{\"v\":-42,\"w\":18446744073709551617,\"x\":7.5e3}");
    // Escaped quotes in key and string, nested object, unknown and empty values.
    send_text("{\"s\\\"q\":\"a\\\"{b}\",\"o\":{\"p\":{}},\"u\":?,\"e\":,\"l\":}");
    // Cut off mid-string; the next start drops the member in progress.
    send_text("{\"a\":\"ab");
    // A brace inside a string still counts toward the object depth.
    send_text("{\"b\":{\"c\":\"}\"}},\"d\":N}");
    send_text("{}");
  endtask

  // More opening braces than the depth counter holds.
  task automatic test_deep_nesting();
    logic [7:0] q[$];
    add_str(q, "{\"d\":");
    repeat (DeepBraces) q.push_back(CH_LBRACE);
    repeat (DeepBraces) q.push_back(CH_RBRACE);
    q.push_back(CH_RBRACE);
    send_doc(q);
  endtask

  task automatic test_random(input int unsigned budget);
    logic [7:0] q[$];
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_document(q);
      send_doc(q);
      if (q[0] == CH_LBRACE) sent += q.size();
    end
  endtask

  // Hold the receiver while short members keep coming, so the result queue
  // fills, the engine stalls and full rises.
  task automatic test_backpressure();
    logic [7:0] q[$];
    int unsigned d, m;
    -> hold_rx_ev;
    for (d = 0; d < 6; d++) begin
      q.delete();
      q.push_back(CH_LBRACE);
      for (m = 0; m < 8; m++) begin
        if (m != 0) q.push_back(CH_COMMA);
        add_str(q, $sformatf("\"%c\":%0d", 8'h61 + m, $urandom_range(999)));
      end
      q.push_back(CH_RBRACE);
      send_doc(q);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    set_idling(22, 66);
    test_directed();
    test_random(RandomBytes);

    set_idling(66, 22);
    test_deep_nesting();
    test_random(RandomBytes);

    set_idling(0, 0);
    test_random(RandomBytes);
    test_backpressure();

    // Drain: wait for every predicted member, then keep waiting to catch any
    // stray result.
    push <= 1'b0;
    while (member_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/jms_pkg.sv
hdl/jms_front.sv
hdl/jms_tok_queue.sv
hdl/jms_back.sv
hdl/jms_res_queue.sv
hdl/json_member_scanner.sv
bench/json_member_scanner_tb.sv
